>>> hw/rtl/bbr_pkg.sv
// Shared types and constants for the box blur row filter.
// Holds parameter defaults, config register indexes and the
// controller/datapath command and status structs. No dependencies.
package bbr_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 31;
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned SCALE_BITS_DEF = 20;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned RADIUS_W    = 5;
  localparam int unsigned ROW_WIDTH_W = 13;

  localparam logic [RADIUS_W-1:0]    RADIUS_RESET    = 5'd1;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;

  typedef enum logic [1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_ROW_WIDTH = 2'd1,
    CFG_SCALE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DROP_ZERO = 2'd0,
    DROP_EDGE = 2'd1,
    DROP_MEM  = 2'd2
  } drop_sel_t;

  typedef struct packed {
    logic      accept;
    logic      prep;
    logic      slide;
    drop_sel_t drop_sel;
    logic      mul;
    logic      load_mean;
    logic      load_pass;
    logic      out_done;
    logic      out_lob;
    logic      flush_start;
    logic      flush_step;
    logic      step_addr;
  } bbr_cmd_t;

  typedef struct packed {
    logic narrow;
    logic early;
    logic has_drop;
    logic last;
    logic rad_zero;
    logic flush_last;
    logic out_busy;
  } bbr_stat_t;

endpackage

>>> hw/rtl/box_blur_row_filter_top.sv
// Box blur row filter top level. An accepted input goes through S_PREP and S_FETCH;
// a narrow-row pass-through item then loads from S_PASS, a window mean goes on via
// S_SLIDE, S_MUL and S_EMIT, an early pixel ends after S_SLIDE. No new input is taken
// until the last is through; the last pixel of a row adds r flushed outputs over the
// registered ring read and shared sum/multiply path; a waiting result holds the FSM.
// Reset (rst_n, synchronous) clears control, sums and row position, reloads config.
module box_blur_row_filter_top
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_red,
  input  logic [PIX_W-1:0]    in_green,
  input  logic [PIX_W-1:0]    in_blue,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_W-1:0]    out_red,
  output logic [PIX_W-1:0]    out_green,
  output logic [PIX_W-1:0]    out_blue,
  output logic                out_last_of_burst,
  output logic                out_row_done,
  output logic                out_config_error,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SCALE_BITS:0] cfg_wdata
);

  bbr_cmd_t  cmd;
  bbr_stat_t stat;

  bbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbr_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .SCALE_BITS (SCALE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ready),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_of_burst (out_last_of_burst),
    .out_row_done      (out_row_done),
    .out_config_error  (out_config_error)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_mean || cmd.load_pass) |-> !stat.out_busy)
    else $error("result loaded while output register held");

  // an accepted item keeps the input closed for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after accept");

  // pass-through items are always single-result bursts
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_config_error) |-> out_last_of_burst)
    else $error("config_error item not marked last of burst");

endmodule

>>> hw/rtl/bbr_datapath.sv
// Datapath of the box blur row filter: config registers, window ring memory,
// running channel sums, reciprocal multiply and the output register.
// Depends on bbr_pkg; driven by bbr_ctrl through bbr_cmd_t.
module bbr_datapath
  import bbr_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned SCALE_BITS = SCALE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [PIX_W-1:0]       in_red,
  input  logic [PIX_W-1:0]       in_green,
  input  logic [PIX_W-1:0]       in_blue,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [SCALE_BITS:0]    cfg_wdata,
  input  logic                   out_ready,
  input  bbr_cmd_t               cmd,
  output bbr_stat_t              stat,
  output logic                   out_valid,
  output logic [PIX_W-1:0]       out_red,
  output logic [PIX_W-1:0]       out_green,
  output logic [PIX_W-1:0]       out_blue,
  output logic                   out_last_of_burst,
  output logic                   out_row_done,
  output logic                   out_config_error
);

  localparam int unsigned RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_WIDTH);
  localparam int unsigned DEPTH  = 2 * MAX_RADIUS + 2;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SUM_W  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int unsigned SC_W   = SCALE_BITS + 1;
  localparam int unsigned PW     = SUM_W + SC_W;
  localparam int unsigned CW     = (LEN_W > RAD_W + 2) ? LEN_W : RAD_W + 2;
  localparam logic [SC_W-1:0] SCALE_RESET = SC_W'(((1 << SCALE_BITS) + 2) / 3);

  // config registers
  logic [RADIUS_W-1:0]    radius_r;
  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [SC_W-1:0]        scale_r;

  // per-row and per-item state
  logic [RAD_W-1:0]            rad_r;
  logic [LEN_W-1:0]            len_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [ADDR_W-1:0]           wp_r;
  logic [ADDR_W-1:0]           rd_addr_r;
  logic [RAD_W-1:0]            fl_r;
  logic                        narrow_r, early_r, has_drop_r, last_r;
  logic [2:0][PIX_W-1:0]       px_r;
  logic [2:0][PIX_W-1:0]       edge_r;
  logic [2:0][PIX_W-1:0]       rd_data_r;
  logic [2:0][SUM_W-1:0]       sum_r;
  logic [2:0][PW-1:0]          prod_r;
  logic [2:0][PIX_W-1:0]       mem [DEPTH];

  logic                        out_valid_r;
  logic [2:0][PIX_W-1:0]       out_px_r;
  logic                        out_done_r, out_lob_r, out_err_r;

  // combinational
  logic [RAD_W-1:0]            rad_c;
  logic [LEN_W-1:0]            len_c;
  logic [CW-1:0]               span_c, i_c, len_cw;
  logic                        narrow_c, early_c, has_drop_c, last_c;
  logic [ADDR_W:0]             span_a, dp_sum;
  logic [ADDR_W-1:0]           dp_c, wp_inc, rd_inc;
  logic [2:0][PIX_W-1:0]       drop_c;
  logic [2:0][PIX_W-1:0]       mean_c;
  logic [2:0][RAD_W+PIX_W:0]   init_c;
  logic [2:0][SUM_W:0]         q_c;
  logic                        mem_we;

  // clamp the row settings latched at row start
  always_comb begin
    if (radius_r > RADIUS_W'(MAX_RADIUS) && RADIUS_W >= RAD_W) begin
      rad_c = RAD_W'(MAX_RADIUS);
    end else if (32'(radius_r) > MAX_RADIUS) begin
      rad_c = RAD_W'(MAX_RADIUS);
    end else begin
      rad_c = RAD_W'(radius_r);
    end
    if (row_width_r == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(row_width_r) > MAX_WIDTH) begin
      len_c = LEN_W'(MAX_WIDTH);
    end else begin
      len_c = LEN_W'(row_width_r);
    end
  end

  // item classification from the latched row settings
  always_comb begin
    span_c     = (CW'(rad_r) << 1) + CW'(1);
    i_c        = CW'(cnt_r);
    len_cw     = CW'(len_r);
    narrow_c   = len_cw < span_c;
    early_c    = i_c < CW'(rad_r);
    has_drop_c = i_c >= span_c;
    last_c     = (i_c + CW'(1)) >= len_cw;
    // drop address is i - (2r+1) modulo the ring depth
    span_a     = ((ADDR_W + 1)'(rad_r) << 1) + (ADDR_W + 1)'(1);
    dp_sum     = {1'b0, wp_r} + (ADDR_W + 1)'(DEPTH) - span_a;
    dp_c       = (dp_sum >= (ADDR_W + 1)'(DEPTH)) ? ADDR_W'(dp_sum - (ADDR_W + 1)'(DEPTH))
                                                  : ADDR_W'(dp_sum);
    wp_inc     = (wp_r == ADDR_W'(DEPTH - 1)) ? '0 : wp_r + ADDR_W'(1);
    rd_inc     = (rd_addr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_addr_r + ADDR_W'(1);
    mem_we     = cmd.prep && !narrow_c;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      init_c[k] = ({1'b0, rad_r} + (RAD_W + 1)'(1)) * (RAD_W + PIX_W + 1)'(px_r[k]);
      case (cmd.drop_sel)
        DROP_EDGE: drop_c[k] = edge_r[k];
        DROP_MEM:  drop_c[k] = rd_data_r[k];
        default:   drop_c[k] = '0;
      endcase
      q_c[k]    = prod_r[k][PW-1:SCALE_BITS];
      mean_c[k] = (|q_c[k][SUM_W:PIX_W]) ? {PIX_W{1'b1}} : q_c[k][PIX_W-1:0];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RESET;
      row_width_r <= ROW_WIDTH_RESET;
      scale_r     <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:    radius_r    <= cfg_wdata[RADIUS_W-1:0];
        CFG_ROW_WIDTH: row_width_r <= cfg_wdata[ROW_WIDTH_W-1:0];
        CFG_SCALE:     scale_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row state, sums and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r      <= '0;
      len_r      <= LEN_W'(1);
      cnt_r      <= '0;
      wp_r       <= '0;
      fl_r       <= '0;
      narrow_r   <= 1'b0;
      early_r    <= 1'b0;
      has_drop_r <= 1'b0;
      last_r     <= 1'b0;
      edge_r     <= '0;
      sum_r      <= '0;
    end else begin
      if (cmd.accept && cnt_r == '0) begin
        rad_r <= rad_c;
        len_r <= len_c;
      end
      if (cmd.prep) begin
        narrow_r   <= narrow_c;
        early_r    <= early_c;
        has_drop_r <= has_drop_c;
        last_r     <= last_c;
        cnt_r      <= last_c ? '0 : cnt_r + CNT_W'(1);
        wp_r       <= last_c ? '0 : wp_inc;
        if (!narrow_c && cnt_r == '0) begin
          edge_r <= px_r;
          for (int k = 0; k < 3; k++) begin
            sum_r[k] <= SUM_W'(init_c[k]);
          end
        end
      end
      if (cmd.slide) begin
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= sum_r[k] + SUM_W'(px_r[k]) - SUM_W'(drop_c[k]);
        end
      end
      if (cmd.flush_start) begin
        fl_r <= rad_r;
      end else if (cmd.flush_step) begin
        fl_r <= fl_r - RAD_W'(1);
      end
    end
  end

  // input capture, drop address and multiply
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= {in_blue, in_green, in_red};
    end
    if (cmd.prep) begin
      rd_addr_r <= dp_c;
    end else if (cmd.step_addr) begin
      rd_addr_r <= rd_inc;
    end
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PW'(sum_r[k]) * PW'(scale_r);
      end
    end
  end

  // window ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= px_r;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_mean || cmd.load_pass) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mean) begin
      out_px_r   <= mean_c;
      out_done_r <= cmd.out_done;
      out_lob_r  <= cmd.out_lob;
      out_err_r  <= 1'b0;
    end else if (cmd.load_pass) begin
      out_px_r   <= px_r;
      out_done_r <= last_r;
      out_lob_r  <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  always_comb begin
    stat.narrow     = narrow_r;
    stat.early      = early_r;
    stat.has_drop   = has_drop_r;
    stat.last       = last_r;
    stat.rad_zero   = (rad_r == '0);
    stat.flush_last = (fl_r == RAD_W'(1));
    stat.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_px_r[0];
  assign out_green         = out_px_r[1];
  assign out_blue          = out_px_r[2];
  assign out_last_of_burst = out_lob_r;
  assign out_row_done      = out_done_r;
  assign out_config_error  = out_err_r;

endmodule

>>> hw/rtl/bbr_ctrl.sv
// Controller of the box blur row filter: sequences capture, window fetch,
// sum update, multiply and result emission, including the end-of-row flush.
// Depends on bbr_pkg; drives bbr_datapath through bbr_cmd_t.
module bbr_ctrl
  import bbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bbr_stat_t stat,
  output bbr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_FETCH,
    S_SLIDE,
    S_MUL,
    S_EMIT,
    S_PASS
  } state_t;

  state_t state_r, state_nxt;
  logic   flushing_r, flushing_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    flushing_nxt = flushing_r;
    in_ready     = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = stat.narrow ? S_PASS : S_SLIDE;
      end
      S_SLIDE: begin
        cmd.slide = 1'b1;
        if (flushing_r || (!stat.early && stat.has_drop)) begin
          cmd.drop_sel = DROP_MEM;
        end else if (stat.early) begin
          cmd.drop_sel = DROP_ZERO;
        end else begin
          cmd.drop_sel = DROP_EDGE;
        end
        // early pixels only build up the sums
        state_nxt = (stat.early && !flushing_r) ? S_IDLE : S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.load_mean = 1'b1;
          if (flushing_r) begin
            cmd.out_done = stat.flush_last;
            cmd.out_lob  = stat.flush_last;
            if (stat.flush_last) begin
              flushing_nxt = 1'b0;
              state_nxt    = S_IDLE;
            end else begin
              cmd.flush_step = 1'b1;
              cmd.step_addr  = 1'b1;
              state_nxt      = S_FETCH;
            end
          end else if (stat.last && !stat.rad_zero) begin
            // row end: r more outputs follow with the last pixel repeated
            cmd.flush_start = 1'b1;
            cmd.step_addr   = 1'b1;
            flushing_nxt    = 1'b1;
            state_nxt       = S_FETCH;
          end else begin
            cmd.out_done = stat.last;
            cmd.out_lob  = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_PASS: begin
        if (!stat.out_busy) begin
          cmd.load_pass = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      flushing_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      flushing_r <= flushing_nxt;
    end
  end

endmodule
